// ===== sv/escm_pkg.sv =====
// ----------------------------------------------------------------------------
// escm_pkg : shared constants, types and exp table for the soft clip mixer
// sample format, register codes and the exp(-x) lookup built at elaboration
// ----------------------------------------------------------------------------
package escm_pkg;

  // sample format
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned FRAC_BITS       = SAMPLE_BITS - 1;
  localparam int unsigned ONE_VAL         = 2 ** FRAC_BITS;

  // exp table: entries cover 0 <= x <= 16 in equal steps
  localparam int unsigned EXP_TABLE_DEPTH = 256;
  localparam int unsigned LOG2_DEPTH      = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned ROM_IDX_W       = LOG2_DEPTH + 1;
  localparam int unsigned RANGE_LOG2      = 4;
  localparam int unsigned SEG_SHIFT       = FRAC_BITS + RANGE_LOG2 - LOG2_DEPTH;

  // configuration registers
  localparam int unsigned GAIN_W          = 16;
  localparam int unsigned GAIN_FRAC       = 8;
  localparam int unsigned MIX_W           = 16;
  localparam int unsigned MIX_FRAC        = 15;
  localparam int unsigned MIX_ONE         = 2 ** MIX_FRAC;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned GAIN_RESET      = 256;
  localparam int unsigned MIX_RESET       = MIX_ONE;

  // derived datapath widths
  localparam int unsigned MAG_W           = SAMPLE_BITS + GAIN_W - GAIN_FRAC;
  localparam int unsigned PROD_W          = MIX_W + 1 + SAMPLE_BITS;
  localparam int unsigned SUM_W           = PROD_W + 2;
  localparam int unsigned NUM_STAGES      = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_GAIN = 1'b0,
    CFG_WET_MIX    = 1'b1
  } cfg_reg_e;

  typedef logic [SAMPLE_BITS-1:0] rom_word_t;
  typedef rom_word_t exp_rom_t [EXP_TABLE_DEPTH+1];

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // (a * b) >> 62, truncated
  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // entry k = exp(-k * 16 / depth), rounded half up to the sample fraction
  function automatic exp_rom_t build_exp_rom();
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] rnd;
    exp_rom_t    rom;
    term = 64'd1 << 58;
    pos  = term;
    neg  = '0;
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = udiv64(term << RANGE_LOG2, 64'(EXP_TABLE_DEPTH) * 64'(n));
        if (n[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
    end
    r = (pos - neg) << 4;
    v = 64'd1 << 62;
    for (int n = 0; n <= int'(EXP_TABLE_DEPTH); n++) begin
      rnd    = (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
      rom[n] = rnd[SAMPLE_BITS-1:0];
      v      = mul_q62(v, r);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ===== sv/exponential_soft_clip_mix.sv =====
// ----------------------------------------------------------------------------
// exponential_soft_clip_mix : exponential waveshaper with wet/dry blend
// y = mix * sign(q) * (1 - exp(-|q|)) + (1 - mix) * x, q = drive * x
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------
//  input   | in_valid_i / in_stall_o    | sample_in_i, block_end_i
//  output  | out_valid_o / out_stall_i  | sample_out_o, block_end_out_o
//  config  | cfg_we_i (no back-pressure)| cfg_index_i, cfg_wdata_i
//
//  one request per cycle sustained while the output is not stalled; five
//  register stages (drive multiply, table lookup, interpolation, mix
//  multiplies, sum and saturation)
//  each stage advances when it is empty or the stage after it advances,
//  so bubbles collapse and a stall at the output backs up stage by stage
//  reset clears the stage valid bits and loads unity drive, full wet mix
//  the exp table is constant logic, so no clearing pass follows reset
//
module exponential_soft_clip_mix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input requests
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [escm_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                               block_end_i,
  // output requests
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [escm_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                               block_end_out_o,
  // register writes
  input  logic                               cfg_we_i,
  input  logic [escm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [escm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import escm_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(ONE_VAL - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] drive_gain_q;
  logic [MIX_W-1:0]  wet_mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q <= GAIN_W'(GAIN_RESET);
      wet_mix_q    <= MIX_W'(MIX_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DRIVE_GAIN: drive_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_WET_MIX:    wet_mix_q    <= cfg_wdata_i[MIX_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage control: valid bits travel with the data, a stage moves when it is
  // empty or its successor moves
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_en;

  always_comb begin
    stage_en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  assign in_stall_o = !stage_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: |x| times drive gain, Q8.8 fraction dropped
  // --------------------------------------------------------------------------
  logic [SB-1:0]            s_abs;
  logic [SB+GAIN_W-1:0]     drive_prod;
  logic [MAG_W-1:0]         mag_d, mag_q;
  logic                     neg0_q;
  logic signed [SB-1:0]     smp0_q;
  logic                     end0_q;

  always_comb begin
    // the most negative sample maps to 2^F, which still fits unsigned
    s_abs      = sample_in_i[SB-1] ? (~sample_in_i + SB'(1)) : sample_in_i;
    drive_prod = {{GAIN_W{1'b0}}, s_abs} * {{SB{1'b0}}, drive_gain_q};
    mag_d      = drive_prod[SB+GAIN_W-1:GAIN_FRAC];
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      mag_q  <= mag_d;
      neg0_q <= sample_in_i[SB-1];
      smp0_q <= sample_in_i;
      end0_q <= block_end_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: table lookup of the two neighbouring entries
  // beyond the table range exp has underflowed, so base and slope go to zero
  // --------------------------------------------------------------------------
  logic                     underflow;
  logic [LOG2_DEPTH-1:0]    seg_idx;
  logic [ROM_IDX_W-1:0]     rom_addr_a, rom_addr_b;
  rom_word_t                rom_a, rom_b;
  logic [SB-1:0]            base_d, base_q;
  logic [SB-1:0]            diff_d, diff_q;
  logic [SEG_SHIFT-1:0]     frac_q;
  logic                     neg1_q;
  logic signed [SB-1:0]     smp1_q;
  logic                     end1_q;

  always_comb begin
    underflow  = |mag_q[MAG_W-1:FRAC_BITS+RANGE_LOG2];
    seg_idx    = mag_q[FRAC_BITS+RANGE_LOG2-1:SEG_SHIFT];
    rom_addr_a = {1'b0, seg_idx};
    rom_addr_b = rom_addr_a + ROM_IDX_W'(1);
    rom_a      = EXP_ROM[rom_addr_a];
    rom_b      = EXP_ROM[rom_addr_b];
    if (underflow) begin
      base_d = '0;
      diff_d = '0;
    end else begin
      base_d = rom_a;
      diff_d = (rom_a >= rom_b) ? (rom_a - rom_b) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      base_q <= base_d;
      diff_q <= diff_d;
      frac_q <= mag_q[SEG_SHIFT-1:0];
      neg1_q <= neg0_q;
      smp1_q <= smp0_q;
      end1_q <= end0_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: linear interpolation, then z = sign * min(1 - e, 1 - lsb)
  // --------------------------------------------------------------------------
  logic [SB+SEG_SHIFT-1:0]  interp_prod;
  logic [SB+SEG_SHIFT:0]    interp_sum;
  logic [SB:0]              drop;
  logic [SB-1:0]            exp_val;
  logic [SB:0]              z_span;
  logic [SB-1:0]            z_mag;
  logic signed [SB-1:0]     z_d, z_q;
  logic signed [SB-1:0]     smp2_q;
  logic                     end2_q;

  always_comb begin
    interp_prod = {{SEG_SHIFT{1'b0}}, diff_q} * {{SB{1'b0}}, frac_q};
    interp_sum  = {1'b0, interp_prod} + (SB+SEG_SHIFT+1)'(2 ** (SEG_SHIFT - 1));
    drop        = interp_sum[SB+SEG_SHIFT:SEG_SHIFT];
    exp_val     = (drop <= {1'b0, base_q}) ? (base_q - drop[SB-1:0]) : '0;
    z_span      = (SB+1)'(ONE_VAL) - {1'b0, exp_val};
    z_mag       = (z_span > (SB+1)'(ONE_VAL - 1)) ? SB'(ONE_VAL - 1) : z_span[SB-1:0];
    z_d         = neg1_q ? (~z_mag + SB'(1)) : z_mag;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[2]) begin
      z_q    <= z_d;
      smp2_q <= smp1_q;
      end2_q <= end1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: wet and dry products, mix above unity limited to unity
  // --------------------------------------------------------------------------
  logic [MIX_W-1:0]         mix_lim;
  logic signed [MIX_W:0]    wet_gain, dry_gain;
  logic signed [PROD_W-1:0] wet_d, wet_q;
  logic signed [PROD_W-1:0] dry_d, dry_q;
  logic                     end3_q;

  always_comb begin
    mix_lim  = (wet_mix_q > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : wet_mix_q;
    wet_gain = {1'b0, mix_lim};
    dry_gain = {1'b0, MIX_W'(MIX_ONE) - mix_lim};
    wet_d    = PROD_W'(wet_gain) * PROD_W'(z_q);
    dry_d    = PROD_W'(dry_gain) * PROD_W'(smp2_q);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[3]) begin
      wet_q  <= wet_d;
      dry_q  <= dry_d;
      end3_q <= end2_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: round, floor shift back to Q1.15 and saturate; output register
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  mix_sum;
  logic signed [SUM_W-1:0]  mix_shr;
  logic signed [SB-1:0]     sample_out_d, sample_out_q;
  logic                     end_out_q;

  always_comb begin
    mix_sum = SUM_W'(wet_q) + SUM_W'(dry_q) + SUM_W'(2 ** (MIX_FRAC - 1));
    mix_shr = mix_sum >>> MIX_FRAC;
    if (mix_shr > SAT_MAX) begin
      sample_out_d = SAT_MAX[SB-1:0];
    end else if (mix_shr < SAT_MIN) begin
      sample_out_d = SAT_MIN[SB-1:0];
    end else begin
      sample_out_d = mix_shr[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[4]) begin
      sample_out_q <= sample_out_d;
      end_out_q    <= end3_q;
    end
  end

  assign out_valid_o     = valid_q[NUM_STAGES-1];
  assign sample_out_o    = sample_out_q;
  assign block_end_out_o = end_out_q;

endmodule

// ===== sv/escm_checker.sv =====
// ----------------------------------------------------------------------------
// escm_checker : port-level checks for the soft clip mixer
// output hold under stall, back-pressure origin and pipeline latency
// ----------------------------------------------------------------------------
module escm_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_o,
  input  logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  input  logic signed [escm_pkg::SAMPLE_BITS-1:0] sample_out_o,
  input  logic                                   block_end_out_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(sample_out_o) && $stable(block_end_out_o))
    else $error("stalled result changed");

  // back-pressure only comes from a full, stalled output
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // a request reaches the output through every stage when nothing stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("request did not arrive after pipeline latency");

endmodule

bind exponential_soft_clip_mix escm_checker u_escm_checker (.*);

// ===== tb/exponential_soft_clip_mix_test.sv =====
// ----------------------------------------------------------------------------
// exponential_soft_clip_mix_test : self-checking bench for the soft clip mixer
// drives sample requests under random gaps and output stalls, predicts every
// result with an independent fixed-point shaper and compares each field
// ----------------------------------------------------------------------------
module exponential_soft_clip_mix_test;

  timeunit 1ns;
  timeprecision 1ps;

  import escm_pkg::*;

  localparam int SW          = SAMPLE_BITS;
  localparam int FB          = FRAC_BITS;
  localparam int EXP_SPAN    = 16;          // table covers exp(-x) for 0 <= x <= 16
  localparam int HOLD_CYCLES = 300;         // long output hold-off
  localparam int TIMEOUT_NS  = 2_000_000;   // far beyond the slowest correct run

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 block_end;
  } mix_result_t;

  // --------------------------------------------------------------------------
  // independent model of the shaper plus the queue of awaited results
  // --------------------------------------------------------------------------
  class ShaperModel;
    longint unsigned exp_table [EXP_TABLE_DEPTH+1];
    logic [GAIN_W-1:0] drive;
    logic [MIX_W-1:0]  wet;
    mix_result_t       awaited [$];
    int                errors;
    int                matched;

    function new();
      longint unsigned term, pos, neg, ratio, v;
      logic [127:0]    prod;
      // exp(-span/depth) from its series in Q.58, then powers in Q.62
      term = 64'd1 << 58;
      pos  = term;
      neg  = 64'd0;
      for (int n = 1; n < 64; n++) begin
        if (term != 64'd0) begin
          term = (term * 64'(EXP_SPAN)) / (64'(EXP_TABLE_DEPTH) * 64'(n));
          if (n % 2 == 1) neg += term;
          else            pos += term;
        end
      end
      ratio = (pos - neg) << 4;
      v     = 64'd1 << 62;
      for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
        exp_table[k] = (v + (64'd1 << (61 - FB))) >> (62 - FB);
        prod         = 128'(v) * 128'(ratio);
        v            = prod[125:62];
      end
      drive   = GAIN_W'(GAIN_RESET);
      wet     = MIX_W'(MIX_RESET);
      errors  = 0;
      matched = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_DRIVE_GAIN: drive = value;
        CFG_WET_MIX:    wet   = value;
        default: ;
      endcase
    endfunction

    function mix_result_t shape_and_blend(logic signed [SW-1:0] s_in, logic be);
      longint      s, mag, p, idx, fr, a, b, d, drop, e, zm, z, m, acc, res;
      mix_result_t r;
      s   = longint'(s_in);
      mag = ((s < 0 ? -s : s) * longint'(drive)) >> GAIN_FRAC;
      if (mag >= (longint'(EXP_SPAN) << FB)) begin
        e = 0;                                    // exp has underflowed
      end else begin
        p    = mag * EXP_TABLE_DEPTH;
        idx  = p >> (FB + 4);
        fr   = p & ((longint'(1) << (FB + 4)) - 1);
        a    = longint'(exp_table[int'(idx)]);
        b    = longint'(exp_table[int'(idx) + 1]);
        d    = (a >= b) ? a - b : 0;
        drop = (d * fr + (longint'(1) << (FB + 3))) >> (FB + 4);
        e    = (drop <= a) ? a - drop : 0;
      end
      zm = (e >= ONE_VAL) ? 0 : ONE_VAL - e;
      if (zm > ONE_VAL - 1) zm = ONE_VAL - 1;
      z   = (s < 0) ? -zm : zm;
      m   = (wet > MIX_ONE) ? MIX_ONE : longint'(wet);
      acc = m * z + (MIX_ONE - m) * s + (MIX_ONE / 2);
      res = acc >>> MIX_FRAC;
      if (res > longint'(ONE_VAL) - 1) res = longint'(ONE_VAL) - 1;
      if (res < -longint'(ONE_VAL)) res = -longint'(ONE_VAL);
      r.sample    = SW'(res);
      r.block_end = be;
      return r;
    endfunction

    function void note_sample(logic signed [SW-1:0] s, logic be);
      awaited.push_back(shape_and_blend(s, be));
    endfunction

    function void check_sample(logic signed [SW-1:0] s, logic be);
      mix_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result sample %0d block_end %0b", $time, s, be);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (s !== want.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, want.sample, s);
        errors++;
      end
      if (be !== want.block_end) begin
        $display("%0t: block_end_out expected %0b actual %0b", $time, want.block_end, be);
        errors++;
      end
      matched++;
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block ports, all inputs driven here known from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic signed [SW-1:0]  sample_in_i = '0;
  logic                  block_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [SW-1:0]  sample_out_o;
  logic                  block_end_out_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  ShaperModel model = new();

  // knobs shared by the driving processes
  int tx_gap_chance = 0;   // percent chance of a gap burst before a request
  bit rx_quiet      = 1'b0;
  bit hold_off_req  = 1'b0;
  int requests      = 0;
  int settings_used = 0;

  exponential_soft_clip_mix DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .block_end_i     (block_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .block_end_out_o (block_end_out_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard limit on the run
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d results still awaited", model.pending());
    $display("exponential_soft_clip_mix_test: FAIL");
    $finish;
  end

  // output side: random stall bursts, a long hold-off on request, none at the end
  initial begin
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 1) == 1);
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  // results are sampled mid-cycle, where both sides are settled; the
  // request then completes at the next rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        model.check_sample(sample_out_o, block_end_out_o);
      end
    end
  end

  // one input request, with an optional gap in front of it
  task automatic offer_sample(input logic signed [SW-1:0] s, input logic be);
    bit taken;
    if (tx_gap_chance != 0 && $urandom_range(1, 100) <= tx_gap_chance) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    block_end_i <= be;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    model.note_sample(s, be);
    requests++;
  endtask

  // stop offering and let every awaited result come out
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 2) @(posedge clk_i);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic load_settings(input logic [CFG_DATA_W-1:0] gain,
                               input logic [CFG_DATA_W-1:0] mix);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_DRIVE_GAIN;
    cfg_wdata_i <= gain;
    @(posedge clk_i);
    model.write_reg(CFG_DRIVE_GAIN, gain);
    cfg_index_i <= CFG_WET_MIX;
    cfg_wdata_i <= mix;
    @(posedge clk_i);
    model.write_reg(CFG_WET_MIX, mix);
    cfg_we_i    <= 1'b0;
    settings_used++;
  endtask

  // mostly uniform samples, with extremes and tiny values mixed in
  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return -(SW'(ONE_VAL));
          1:       return SW'(ONE_VAL - 1);
          2:       return '0;
          3:       return SW'(-1);
          default: return SW'(1);
        endcase
      end
      1:       return SW'($signed($urandom_range(0, 128)) - 64);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      offer_sample(pick_sample(), $urandom_range(0, 7) == 0);
    end
    drain_pipeline();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings first (unity drive, fully wet)
    offer_sample('0, 1'b0);
    offer_sample(SW'(ONE_VAL - 1), 1'b1);
    offer_sample(-(SW'(ONE_VAL)), 1'b0);
    offer_sample(SW'(1), 1'b0);
    offer_sample(SW'(-1), 1'b1);
    offer_sample(SW'(16384), 1'b0);
    offer_sample(SW'(-16384), 1'b0);
    drain_pipeline();

    // full drive: exp underflow on both signs
    load_settings(16'hFFFF, 16'(MIX_ONE));
    offer_sample(SW'(ONE_VAL - 1), 1'b0);
    offer_sample(-(SW'(ONE_VAL)), 1'b1);
    offer_sample(SW'(1), 1'b0);
    offer_sample(SW'(-1), 1'b0);
    offer_sample('0, 1'b1);
    drain_pipeline();

    // zero drive and fully dry
    load_settings('0, '0);
    offer_sample(SW'(12345), 1'b0);
    offer_sample(-(SW'(ONE_VAL)), 1'b1);
    offer_sample(SW'(ONE_VAL - 1), 1'b0);
    drain_pipeline();

    // zero drive, fully wet gives silence
    load_settings('0, 16'(MIX_ONE));
    offer_sample(SW'(-20000), 1'b0);
    offer_sample(SW'(ONE_VAL - 1), 1'b1);
    drain_pipeline();

    // mix above unity is clamped
    load_settings(16'd256, 16'hFFFF);
    offer_sample(SW'(20000), 1'b0);
    offer_sample(SW'(-20000), 1'b1);
    offer_sample(-(SW'(ONE_VAL)), 1'b0);
    drain_pipeline();

    // random phases over a spread of settings
    for (int ph = 0; ph < 8; ph++) begin
      tx_gap_chance = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
      case (ph)
        0: load_settings(16'($urandom), 16'($urandom_range(0, MIX_ONE)));
        1: load_settings(16'($urandom_range(0, 511)), 16'(MIX_ONE));
        2: load_settings(16'hFFFF, '0);
        3: load_settings(16'($urandom_range(0, 2047)), 16'($urandom));
        4: load_settings('0, 16'(MIX_ONE));
        5: load_settings(16'd256, 16'($urandom_range(MIX_ONE + 1, 65535)));
        6: load_settings(16'($urandom), 16'($urandom));
        default: load_settings(16'($urandom_range(128, 1024)),
                               16'($urandom_range(0, MIX_ONE)));
      endcase
      random_phase(140);
    end

    // long hold-off at the output while requests keep coming, so the
    // pipeline fills and stalls its input
    load_settings(16'($urandom_range(64, 4096)), 16'($urandom_range(0, MIX_ONE)));
    tx_gap_chance = 0;
    hold_off_req  = 1'b1;
    random_phase(40);

    // closing stretch with no idling on either side; let any stall burst end
    rx_quiet = 1'b1;
    repeat (14) @(posedge clk_i);
    load_settings(16'($urandom), 16'($urandom_range(0, MIX_ONE)));
    random_phase(60);

    $display("covered %0d sample requests over %0d register settings, incl. drive and mix",
             requests, settings_used);
    $display("extremes, zero drive, exp underflow and a long output hold-off; %0d checked",
             model.matched);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("exponential_soft_clip_mix_test: PASS");
    end else begin
      $display("exponential_soft_clip_mix_test: FAIL");
    end
    $finish;
  end

endmodule
